// ----- src/pau_pkg.sv -----
// Package for the two-objective Pareto archive: field widths, command and
// status codes, sequencer states and the compare unit result type.
// No dependencies.
`default_nettype none

package pau_pkg;

  // field widths of the input and result words
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ObjW   = 32;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 6;

  // command codes, the fourth code is ignored
  typedef enum logic [CmdW-1:0] {
    CMD_OFFER = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_DONE     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RDREQ,
    S_DONE
  } state_e;

  // outcome of comparing the candidate against one slot
  typedef struct packed {
    logic covered;    // valid entry no worse in both objectives
    logic dominated;  // valid entry that the candidate weakly dominates
    logic slot_free;  // slot usable for the candidate if it is kept
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- src/pau_if.sv -----
// Valid/ready channel interfaces for the Pareto archive: input command word
// and result word. Depends on pau_pkg for the field widths.
`default_nettype none

interface pau_in_if
  import pau_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [ObjW-1:0]  cand_makespan;
  logic [ObjW-1:0]  cand_energy;
  logic [SlotW-1:0] read_slot;

  modport source (output valid, command, cand_makespan, cand_energy, read_slot,
                  input ready);
  modport sink   (input valid, command, cand_makespan, cand_energy, read_slot,
                  output ready);
endinterface

interface pau_out_if
  import pau_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [CountW-1:0] removed_count;
  logic [CountW-1:0] entry_count;
  logic              slot_valid;
  logic [ObjW-1:0]   slot_makespan;
  logic [ObjW-1:0]   slot_energy;

  modport source (output valid, status, removed_count, entry_count, slot_valid,
                  slot_makespan, slot_energy, input ready);
  modport sink   (input valid, status, removed_count, entry_count, slot_valid,
                  slot_makespan, slot_energy, output ready);
endinterface

`default_nettype wire

// ----- src/pareto_archive_update.sv -----
// Two-objective Pareto archive top level: sequencer, slot memory, valid bits
// and result register. Depends on pau_pkg, pau_if and pau_cmp.
//
// Usage: commands enter on in_i (valid/ready), one result word leaves on
// out_o (valid/ready) for every command word. An offer scans all
// ARCHIVE_DEPTH slots through a single compare unit, one slot per cycle, then
// drops the entries the candidate dominates and writes it into the lowest
// free slot, or reports it rejected or the archive full.
// An offer passes through the scan, drain and done states, a read through a
// memory read request and the done state, clear and the unused code go
// straight to the done state. One command is worked on at a time: in_i.ready
// is high only while the sequencer is idle, so the next offer waits for the
// slot scan through the one memory read port and the commit to finish.
// The result sits in an output register, so the next word is accepted while
// a result still waits; if the receiver stalls longer, the finishing command
// holds in its last step until the register frees up.
// Reset empties the archive at once (valid bits and count); the slot memory
// is not cleared, and its contents are only seen behind a valid bit.
`default_nettype none

module pareto_archive_update
  import pau_pkg::*;
#(
  parameter int unsigned ARCHIVE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pau_in_if.sink    in_i,
  pau_out_if.source out_o
);

  localparam int unsigned AW = $clog2(ARCHIVE_DEPTH);
  localparam int unsigned CW = $clog2(ARCHIVE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(ARCHIVE_DEPTH - 1);

  state_e state_q, state_d;

  // latched command word
  logic [CmdW-1:0]  cmd_q;
  logic [ObjW-1:0]  cm_q;
  logic [ObjW-1:0]  ce_q;
  logic [SlotW-1:0] rs_q;

  // archive state
  logic [ARCHIVE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]            total_q, total_d;
  logic [2*ObjW-1:0]        entry_mem [ARCHIVE_DEPTH];
  logic [2*ObjW-1:0]        rd_data_q;

  // scan bookkeeping
  logic [AW-1:0]            idx_q;
  logic                     chk_q;
  logic [AW-1:0]            chk_idx_q;
  logic [ARCHIVE_DEPTH-1:0] dom_q;
  logic                     reject_q;
  logic [CW-1:0]            removed_q;
  logic                     free_found_q;
  logic [AW-1:0]            free_idx_q;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [CountW-1:0] removed_out_q, removed_out_d;
  logic [CountW-1:0] count_out_q, count_out_d;
  logic              sv_q, sv_d;
  logic [ObjW-1:0]   sm_q, sm_d;
  logic [ObjW-1:0]   se_q, se_d;

  // sequencer outputs
  logic          in_fire;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          out_free;
  logic          done_fire;
  logic          wr_en;

  logic [AW-1:0] rs_addr;
  logic          rs_ok;
  cmp_res_t      cmp;
  logic [CW-1:0] total_rm;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign rs_addr  = AW'(rs_q);
  assign rs_ok    = ({{(32 - SlotW){1'b0}}, rs_q} < 32'(ARCHIVE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.command == CMD_OFFER) begin
            state_d = S_SCAN;
          end else if (in_i.command == CMD_READ) begin
            state_d = S_RDREQ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == LastIdx) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DONE;
      S_RDREQ: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    done_fire  = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_SCAN:  rd_en = 1'b1;
      S_RDREQ: begin
        rd_en   = 1'b1;
        rd_addr = rs_addr;
      end
      S_DONE:  done_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command latch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.command;
      cm_q  <= in_i.cand_makespan;
      ce_q  <= in_i.cand_energy;
      rs_q  <= in_i.read_slot;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) entry_mem[free_idx_q] <= {cm_q, ce_q};
    if (rd_en) rd_data_q <= entry_mem[rd_addr];
  end

  // shared compare unit on the slot read last cycle
  pau_cmp u_cmp (
    .cand_makespan_i  (cm_q),
    .cand_energy_i    (ce_q),
    .entry_valid_i    (valid_q[chk_idx_q]),
    .entry_makespan_i (rd_data_q[2*ObjW-1:ObjW]),
    .entry_energy_i   (rd_data_q[ObjW-1:0]),
    .res_o            (cmp)
  );

  // scan counter and compare pipeline flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      chk_q     <= (state_q == S_SCAN);
      chk_idx_q <= idx_q;
      if (in_fire) begin
        idx_q <= '0;
      end else if (state_q == S_SCAN) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_q        <= '0;
      reject_q     <= 1'b0;
      removed_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else if (in_fire) begin
      reject_q     <= 1'b0;
      removed_q    <= '0;
      free_found_q <= 1'b0;
    end else if (chk_q) begin
      dom_q[chk_idx_q] <= cmp.dominated;
      if (cmp.covered) reject_q <= 1'b1;
      if (cmp.dominated) removed_q <= removed_q + CW'(1);
      if (!free_found_q && cmp.slot_free) begin
        free_found_q <= 1'b1;
        free_idx_q   <= chk_idx_q;
      end
    end
  end

  assign total_rm = total_q - removed_q;

  // commit step: archive update and result word
  always_comb begin
    valid_d       = valid_q;
    total_d       = total_q;
    wr_en         = 1'b0;
    status_d      = STAT_DONE;
    removed_out_d = '0;
    count_out_d   = CountW'(total_q);
    sv_d          = 1'b0;
    sm_d          = '0;
    se_d          = '0;
    if (done_fire) begin
      unique case (cmd_q)
        CMD_OFFER: begin
          if (reject_q) begin
            status_d = STAT_REJECTED;
          end else if (!free_found_q) begin
            status_d = STAT_FULL;
          end else begin
            valid_d             = valid_q & ~dom_q;
            valid_d[free_idx_q] = 1'b1;
            total_d             = total_rm + CW'(1);
            wr_en               = 1'b1;
            status_d            = STAT_INSERTED;
            removed_out_d       = CountW'(removed_q);
            count_out_d         = CountW'(total_d);
          end
        end
        CMD_READ: begin
          if (rs_ok && valid_q[rs_addr]) begin
            sv_d = 1'b1;
            sm_d = rd_data_q[2*ObjW-1:ObjW];
            se_d = rd_data_q[ObjW-1:0];
          end
        end
        CMD_CLEAR: begin
          valid_d     = '0;
          total_d     = '0;
          count_out_d = '0;
        end
        default: ;
      endcase
    end
  end

  // archive valid bits and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
    end else begin
      valid_q <= valid_d;
      total_q <= total_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (done_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      status_q      <= status_d;
      removed_out_q <= removed_out_d;
      count_out_q   <= count_out_d;
      sv_q          <= sv_d;
      sm_q          <= sm_d;
      se_q          <= se_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_count = removed_out_q;
  assign out_o.entry_count   = count_out_q;
  assign out_o.slot_valid    = sv_q;
  assign out_o.slot_makespan = sm_q;
  assign out_o.slot_energy   = se_q;

  // count never exceeds the archive depth
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(ARCHIVE_DEPTH))
    else $error("entry count above archive depth");

  // count tracks the valid bits whenever the sequencer is idle
  a_total_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> int'(total_q) == $countones(valid_q))
    else $error("entry count out of step with valid bits");

  // a full archive report never comes with removed entries
  a_full_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire && status_d == STAT_FULL |-> removed_q == '0)
    else $error("archive full reported after removals");

  // an insert always lands in a slot that was free or freed by this offer
  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !valid_q[free_idx_q] || dom_q[free_idx_q])
    else $error("insert overwrote a live entry");

endmodule

`default_nettype wire

// ----- src/pau_cmp.sv -----
// Shared dominance compare unit: checks the candidate against one archive
// slot per cycle. Depends on pau_pkg.
`default_nettype none

module pau_cmp
  import pau_pkg::*;
(
  input  wire logic [ObjW-1:0] cand_makespan_i,
  input  wire logic [ObjW-1:0] cand_energy_i,
  input  wire logic            entry_valid_i,
  input  wire logic [ObjW-1:0] entry_makespan_i,
  input  wire logic [ObjW-1:0] entry_energy_i,
  output cmp_res_t             res_o
);

  logic ms_le;  // entry makespan <= candidate makespan
  logic en_le;  // entry energy <= candidate energy
  logic ms_ge;  // candidate makespan <= entry makespan
  logic en_ge;  // candidate energy <= entry energy

  // magnitude compares
  assign ms_le = (entry_makespan_i <= cand_makespan_i);
  assign en_le = (entry_energy_i <= cand_energy_i);
  assign ms_ge = (cand_makespan_i <= entry_makespan_i);
  assign en_ge = (cand_energy_i <= entry_energy_i);

  // dominance outcome for this slot
  assign res_o.covered   = entry_valid_i && ms_le && en_le;
  assign res_o.dominated = entry_valid_i && ms_ge && en_ge;
  assign res_o.slot_free = !entry_valid_i || (ms_ge && en_ge);

endmodule

`default_nettype wire
